// File: rtl/esod_pkg.sv
// ----------------------------------------------------------------------------
// esod_pkg
// Shared types, microcode addresses and control store of the EMA
// send-on-delta filter.
// ----------------------------------------------------------------------------
package esod_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned AVG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned UC_AW      = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SMOOTHING  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_DELTA      = cfg_idx_t'(1);
  localparam cfg_idx_t REG_DELTA_TIME = cfg_idx_t'(2);
  localparam cfg_idx_t REG_MAX_AGE    = cfg_idx_t'(3);

  localparam logic [15:0] SMOOTHING_RESET = 16'd6554;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CHK,
    OP_GAP,
    OP_MUL,
    OP_ACC,
    OP_DEV,
    OP_CMPD,
    OP_CMPT,
    OP_FIRE,
    OP_OUT
  } dp_op_e;

  typedef enum logic [1:0] {
    W_NONE,
    W_IN,
    W_OUT
  } wait_e;

  typedef enum logic [1:0] {
    B_SEQ,
    B_ALWAYS,
    B_HIT,
    B_MISS
  } branch_e;

  typedef logic [UC_AW-1:0] uaddr_t;

  localparam uaddr_t A_IDLE = uaddr_t'(0);
  localparam uaddr_t A_CHK  = uaddr_t'(1);
  localparam uaddr_t A_GAP  = uaddr_t'(2);
  localparam uaddr_t A_MUL  = uaddr_t'(3);
  localparam uaddr_t A_ACC  = uaddr_t'(4);
  localparam uaddr_t A_DEV  = uaddr_t'(5);
  localparam uaddr_t A_CMPD = uaddr_t'(6);
  localparam uaddr_t A_CMPT = uaddr_t'(7);
  localparam uaddr_t A_FIRE = uaddr_t'(8);
  localparam uaddr_t A_OUT  = uaddr_t'(9);

  typedef struct packed {
    dp_op_e  op;
    wait_e   wt;
    branch_e br;
    uaddr_t  target;
  } ucw_t;

  typedef struct packed {
    dp_op_e op;
    logic   load;
  } dp_ctrl_t;

  typedef struct packed {
    logic hit;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic [15:0]           k;
    logic [CFG_DATA_W-1:0] dt;
    logic [CFG_DATA_W-1:0] dtt;
    logic [CFG_DATA_W-1:0] ma;
  } cfg_t;

  // control store
  function automatic ucw_t ucode(uaddr_t a);
    ucw_t w;
    unique case (a)
      A_IDLE:  w = '{op: OP_LOAD, wt: W_IN,   br: B_SEQ,    target: A_IDLE};
      A_CHK:   w = '{op: OP_CHK,  wt: W_NONE, br: B_HIT,    target: A_FIRE};
      A_GAP:   w = '{op: OP_GAP,  wt: W_NONE, br: B_SEQ,    target: A_IDLE};
      A_MUL:   w = '{op: OP_MUL,  wt: W_NONE, br: B_SEQ,    target: A_IDLE};
      A_ACC:   w = '{op: OP_ACC,  wt: W_NONE, br: B_SEQ,    target: A_IDLE};
      A_DEV:   w = '{op: OP_DEV,  wt: W_NONE, br: B_SEQ,    target: A_IDLE};
      A_CMPD:  w = '{op: OP_CMPD, wt: W_NONE, br: B_HIT,    target: A_FIRE};
      A_CMPT:  w = '{op: OP_CMPT, wt: W_NONE, br: B_MISS,   target: A_OUT};
      A_FIRE:  w = '{op: OP_FIRE, wt: W_NONE, br: B_SEQ,    target: A_IDLE};
      A_OUT:   w = '{op: OP_OUT,  wt: W_OUT,  br: B_ALWAYS, target: A_IDLE};
      default: w = '{op: OP_NOP,  wt: W_NONE, br: B_ALWAYS, target: A_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/esod_useq.sv
// ----------------------------------------------------------------------------
// esod_useq
// Microprogram sequencer: step counter, control store lookup, wait and
// conditional jump handling, input handshake.
// ----------------------------------------------------------------------------
module esod_useq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  esod_pkg::dp_status_t status_i,
  output esod_pkg::dp_ctrl_t  ctrl_o
);
  import esod_pkg::*;

  uaddr_t upc_q, upc_d;
  ucw_t   cw;
  uaddr_t upc_inc;
  logic   in_acc;

  assign cw      = ucode(upc_q);
  assign upc_inc = uaddr_t'(upc_q + 1'b1);

  assign in_stall_o = (cw.wt != W_IN);
  assign in_acc     = in_valid_i && (cw.wt == W_IN);

  assign ctrl_o.op   = cw.op;
  assign ctrl_o.load = in_acc;

  always_comb begin
    if (cw.wt == W_IN && !in_valid_i) begin
      upc_d = upc_q;
    end else if (cw.wt == W_OUT && status_i.out_busy) begin
      upc_d = upc_q;
    end else begin
      unique case (cw.br)
        B_SEQ:    upc_d = upc_inc;
        B_ALWAYS: upc_d = cw.target;
        B_HIT:    upc_d = status_i.hit ? cw.target : upc_inc;
        B_MISS:   upc_d = status_i.hit ? upc_inc : cw.target;
        default:  upc_d = A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= A_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  a_acc_to_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> upc_q == A_CHK)
    else $error("accepted request did not start the check step");

  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q <= A_OUT)
    else $error("step counter outside the program");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == A_OUT && status_i.out_busy) |=> upc_q == A_OUT)
    else $error("left output step while result register busy");

endmodule

// File: rtl/esod_dpath.sv
// ----------------------------------------------------------------------------
// esod_dpath
// Datapath: filter state, operand registers, one shared signed multiplier,
// compare logic and the output register.
// ----------------------------------------------------------------------------
module esod_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  esod_pkg::dp_ctrl_t          ctrl_i,
  output esod_pkg::dp_status_t        status_o,
  input  esod_pkg::cfg_t              cfg_i,
  input  logic signed [15:0]          sample_i,
  input  logic [31:0]                 timestamp_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic                        triggered_o,
  output logic signed [15:0]          reported_value_o,
  output logic signed [31:0]          filtered_value_o
);
  import esod_pkg::*;

  logic                       have_q;
  logic [AVG_W-1:0]           avg_q;
  logic [SAMPLE_W-1:0]        lr_q;
  logic [TIME_W-1:0]          ltt_q;
  logic                       trig_q;
  logic                       out_valid_q;

  logic [SAMPLE_W-1:0]        s_q;
  logic [TIME_W-1:0]          t_q;
  logic [TIME_W-1:0]          elapsed_q;
  logic signed [32:0]         opa_q;
  logic signed [32:0]         opb_q;
  logic [63:0]                prod_q;
  logic                       out_trig_q;
  logic [SAMPLE_W-1:0]        out_lr_q;
  logic [AVG_W-1:0]           out_avg_q;

  logic [TIME_W-1:0]          elapsed;
  logic signed [65:0]         mul;
  logic [32:0]                gap;
  logic [32:0]                diff;
  logic [32:0]                absv;
  logic                       hit;
  logic                       out_busy;
  logic                       out_load;

  assign elapsed  = t_q - ltt_q;
  assign mul      = opa_q * opb_q;
  assign gap      = {s_q[15], s_q, 16'h0000} - {avg_q[31], avg_q};
  assign diff     = {avg_q[31], avg_q} - {lr_q[15], lr_q, 16'h0000};
  assign absv     = diff[32] ? (33'd0 - diff) : diff;
  assign out_busy = out_valid_q && out_stall_i;
  assign out_load = (ctrl_i.op == OP_OUT) && !out_busy;

  always_comb begin
    unique case (ctrl_i.op)
      OP_CHK:  hit = !have_q || (cfg_i.ma != '0 && elapsed > cfg_i.ma);
      OP_CMPD: hit = (cfg_i.dt != '0) && (opa_q[31:0] > cfg_i.dt);
      OP_CMPT: hit = (cfg_i.dtt != '0) && (prod_q > {16'h0000, cfg_i.dtt, 16'h0000});
      default: hit = 1'b0;
    endcase
  end

  assign status_o.hit      = hit;
  assign status_o.out_busy = out_busy;

  // filter state and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      avg_q       <= '0;
      lr_q        <= '0;
      ltt_q       <= '0;
      trig_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.load) begin
        trig_q <= 1'b0;
      end
      if (ctrl_i.op == OP_ACC) begin
        avg_q <= avg_q + prod_q[47:16];
      end
      if (ctrl_i.op == OP_FIRE) begin
        have_q <= 1'b1;
        avg_q  <= {s_q, 16'h0000};
        lr_q   <= s_q;
        ltt_q  <= t_q;
        trig_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operands and result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      s_q <= sample_i;
      t_q <= timestamp_i;
    end
    case (ctrl_i.op) inside
      OP_CHK: begin
        elapsed_q <= elapsed;
      end
      OP_GAP: begin
        opa_q <= gap;
        opb_q <= {17'd0, cfg_i.k};
      end
      OP_MUL, OP_CMPD: begin
        prod_q <= mul[63:0];
      end
      OP_DEV: begin
        opa_q <= {1'b0, absv[31:0]};
        opb_q <= {1'b0, elapsed_q};
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_trig_q <= trig_q;
      out_lr_q   <= lr_q;
      out_avg_q  <= avg_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign triggered_o      = out_trig_q;
  assign reported_value_o = out_lr_q;
  assign filtered_value_o = out_avg_q;

  a_fire_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_FIRE) |=> have_q && trig_q && lr_q == $past(s_q)
      && avg_q == {$past(s_q), 16'h0000})
    else $error("trigger did not reload filter state");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && out_trig_q == $past(trig_q))
    else $error("result register not loaded");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q
      && $stable({out_trig_q, out_lr_q, out_avg_q}))
    else $error("stalled result changed");

endmodule

// File: rtl/ema_send_on_delta_filter.sv
// ----------------------------------------------------------------------------
// ema_send_on_delta_filter
// Send-on-delta filter on an exponential moving average of timestamped
// samples, run by a short microprogram over a shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  in       | request   | in_valid_i/in_stall_o  | sample_i, timestamp_i
//  out      | result    | out_valid_o/out_stall_i| triggered_o, reported_value_o,
//           |           |                        | filtered_value_o
//  cfg      | write     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One request at a time, on the single 33x33 multiplier: a full pass runs
//  the check, gap, multiply, accumulate, deviation and compare steps, then
//  fire if a compare hits, and output; first sample or max age skip to fire.
//  The next request is taken while a result still waits in the output
//  register; a stalled result holds the program at its output step.
//  Reset clears the filter state and loads the register defaults.
// ----------------------------------------------------------------------------
module ema_send_on_delta_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [15:0]                  sample_i,
  input  logic [31:0]                         timestamp_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                triggered_o,
  output logic signed [15:0]                  reported_value_o,
  output logic signed [31:0]                  filtered_value_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  esod_pkg::cfg_idx_t                  cfg_index_i,
  input  logic [esod_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import esod_pkg::*;

  cfg_t       cfg_q;
  dp_ctrl_t   ctrl;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k   <= SMOOTHING_RESET;
      cfg_q.dt  <= '0;
      cfg_q.dtt <= '0;
      cfg_q.ma  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SMOOTHING:  cfg_q.k   <= cfg_data_i[15:0];
        REG_DELTA:      cfg_q.dt  <= cfg_data_i;
        REG_DELTA_TIME: cfg_q.dtt <= cfg_data_i;
        REG_MAX_AGE:    cfg_q.ma  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  esod_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  esod_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .cfg_i            (cfg_q),
    .sample_i         (sample_i),
    .timestamp_i      (timestamp_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .triggered_o      (triggered_o),
    .reported_value_o (reported_value_o),
    .filtered_value_o (filtered_value_o)
  );

endmodule

// File: bench/tb_ema_send_on_delta_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ema_send_on_delta_filter
// Self-checking bench for the EMA send-on-delta filter. A local fixed-point
// filter model predicts trigger, reported value and average for each accepted
// sample. Directed cases cover field extremes, each trigger path, wrapping
// timestamps and an ignored register index. Random phases then rewrite the
// registers between phases while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_ema_send_on_delta_filter;
  import esod_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 135;

  typedef struct packed {
    logic               trig;
    logic signed [15:0] rep;
    logic signed [31:0] filt;
  } report_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [15:0]      sample_i = '0;
  logic [31:0]             timestamp_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    triggered_o;
  logic signed [15:0]      reported_value_o;
  logic signed [31:0]      filtered_value_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  cfg_idx_t                cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  // filter model state and registers
  logic                    m_have = 1'b0;
  logic signed [31:0]      m_avg = '0;
  logic signed [15:0]      m_last_rep = '0;
  logic [31:0]             m_last_time = '0;
  logic [15:0]             r_k = SMOOTHING_RESET;
  logic [31:0]             r_dt = '0;
  logic [31:0]             r_dtt = '0;
  logic [31:0]             r_ma = '0;

  report_t                 expected_reports[$];

  int unsigned             n_accepted = 0;
  int unsigned             n_checked = 0;
  int unsigned             n_triggers = 0;
  int unsigned             n_reg_writes = 0;
  int unsigned             n_mismatch = 0;
  int unsigned             n_errors = 0;

  int unsigned             tx_gap_pct = 30;
  int unsigned             rx_stall_pct = 30;
  bit                      hold_req = 1'b0;
  bit                      hold_active = 1'b0;

  logic signed [15:0]      s_walk = '0;
  logic [31:0]             t_walk = '0;

  ema_send_on_delta_filter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .timestamp_i      (timestamp_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .triggered_o      (triggered_o),
    .reported_value_o (reported_value_o),
    .filtered_value_o (filtered_value_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic report_t filter_predict(logic signed [15:0] smp, logic [31:0] ts);
    report_t            r;
    logic [31:0]        elapsed;
    longint             gap;
    longint             incr;
    longint             dv;
    longint unsigned    dev;
    longint unsigned    tlim;
    logic               fire;
    fire = 1'b0;
    elapsed = ts - m_last_time;
    if (!m_have) begin
      fire = 1'b1;
    end else if (r_ma != 0 && elapsed > r_ma) begin
      fire = 1'b1;
    end else begin
      gap = longint'(smp) * 65536 - longint'(m_avg);
      incr = (gap * longint'(r_k)) >>> 16;
      m_avg = 32'(longint'(m_avg) + incr);
      dv = longint'(m_avg) - longint'(m_last_rep) * 65536;
      dev = (dv < 0) ? -dv : dv;
      tlim = longint'(r_dtt) << 16;
      if (r_dt != 0 && dev > longint'(r_dt)) begin
        fire = 1'b1;
      end else if (r_dtt != 0 && dev * longint'(elapsed) > tlim) begin
        fire = 1'b1;
      end
    end
    if (fire) begin
      m_have = 1'b1;
      m_avg = {smp, 16'h0000};
      m_last_rep = smp;
      m_last_time = ts;
    end
    r.trig = fire;
    r.rep = m_last_rep;
    r.filt = m_avg;
    return r;
  endfunction

  // request/result monitor and scoreboard
  always @(posedge clk_i) begin
    report_t exp_r;
    report_t got_r;
    if (cfg_valid_i && cfg_ready_o) begin
      n_reg_writes++;
      case (cfg_index_i)
        REG_SMOOTHING:  r_k = cfg_data_i[15:0];
        REG_DELTA:      r_dt = cfg_data_i;
        REG_DELTA_TIME: r_dtt = cfg_data_i;
        REG_MAX_AGE:    r_ma = cfg_data_i;
        default: ;
      endcase
    end
    if (out_valid_o && !out_stall_i) begin
      got_r.trig = triggered_o;
      got_r.rep = reported_value_o;
      got_r.filt = filtered_value_o;
      n_checked++;
      if (got_r.trig === 1'b1) n_triggers++;
      if (expected_reports.size() == 0) begin
        n_errors++;
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: trig=%b rep=%0d filt=%0d",
                   got_r.trig, got_r.rep, got_r.filt);
      end else begin
        exp_r = expected_reports.pop_front();
        if (got_r.trig !== exp_r.trig || got_r.rep !== exp_r.rep ||
            got_r.filt !== exp_r.filt) begin
          n_errors++;
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch #%0d: trig exp %b got %b, rep exp %0d got %0d, filt exp %0d got %0d",
                     n_checked, exp_r.trig, got_r.trig, exp_r.rep, got_r.rep,
                     exp_r.filt, got_r.filt);
        end
      end
    end
    if (in_valid_i && !in_stall_o) begin
      n_accepted++;
      expected_reports.push_back(filter_predict(sample_i, timestamp_i));
    end
  end

  function automatic int unsigned pick_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver stall pattern, with an optional long hold
  initial begin : rx_stall
    int unsigned n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        out_stall_i <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        hold_active = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
        repeat (pick_len()) @(posedge clk_i);
      end
    end
  end

  task automatic offer_sample(logic signed [15:0] smp, logic [31:0] ts);
    int unsigned n;
    n = ($urandom_range(0, 99) < tx_gap_pct) ? pick_len() : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= smp;
    timestamp_i <= ts;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    // let the monitor record a request taken at this edge
    @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_filter(logic [15:0] k, logic [31:0] dt, logic [31:0] dtt,
                                logic [31:0] ma);
    quiesce();
    write_reg(REG_SMOOTHING, {16'($urandom), k});
    write_reg(REG_DELTA, dt);
    write_reg(REG_DELTA_TIME, dtt);
    write_reg(REG_MAX_AGE, ma);
  endtask

  task automatic test_first_sample();
    offer_sample(-16'sd32768, 32'h0000_0000);
    offer_sample(16'sd32767, 32'hFFFF_FFFF);
    offer_sample(16'sd0, 32'h0000_0005);
    offer_sample(-16'sd1, 32'h0000_0007);
  endtask

  task automatic test_delta_check();
    program_filter(16'hFFFF, 32'h0001_0000, 32'h0, 32'h0);
    offer_sample(16'sd10, 32'd100);
    offer_sample(16'sd10, 32'd101);
    offer_sample(16'sd12, 32'd102);
    program_filter(16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    offer_sample(-16'sd32768, 32'd200);
    offer_sample(16'sd32767, 32'd201);
  endtask

  task automatic test_time_check();
    // zero smoothing: average frozen, only the time check can fire
    program_filter(16'h0000, 32'h0, 32'h0000_0001, 32'h0);
    offer_sample(16'sd100, 32'd300);
    offer_sample(16'sd5000, 32'd301);
    offer_sample(16'sd5000, 32'd250);
    program_filter(16'h8000, 32'h0, 32'hFFFF_FFFF, 32'h0);
    offer_sample(16'sd0, 32'hFFFF_FFF0);
    offer_sample(16'sd32767, 32'h0000_0010);
  endtask

  task automatic test_max_age();
    program_filter(16'h1999, 32'h0, 32'h0, 32'h0000_0001);
    offer_sample(16'sd7, 32'd1000);
    offer_sample(16'sd8, 32'd1001);
    offer_sample(16'sd9, 32'd1002);
    program_filter(16'h1999, 32'h0, 32'h0, 32'hFFFF_FFFF);
    offer_sample(-16'sd5, 32'h0000_0010);
  endtask

  task automatic test_ignored_index();
    quiesce();
    write_reg(cfg_idx_t'($urandom_range(int'(REG_MAX_AGE) + 1, 15)), $urandom);
    offer_sample(16'sh55AA, 32'hAAAA_5555);
    offer_sample(-16'sh55AB, 32'h5555_AAAA);
  endtask

  task automatic test_backpressure();
    int unsigned i;
    program_filter(16'h4000, 32'h0004_0000, 32'd50, 32'd40);
    tx_gap_pct = 0;
    hold_req = 1'b1;
    wait (hold_active);
    for (i = 0; i < 16; i++) begin
      t_walk = t_walk + $urandom_range(0, 20);
      offer_sample(16'($urandom), t_walk);
    end
    tx_gap_pct = 30;
  endtask

  function automatic logic [31:0] rand_thr(int unsigned typical_hi);
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return $urandom;
      2:       return $urandom_range(1, 3);
      default: return $urandom_range(1, typical_hi);
    endcase
  endfunction

  task automatic test_random_mix();
    int unsigned p;
    int unsigned i;
    int unsigned sel;
    logic [15:0] k;
    for (p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        program_filter(16'h0000, 32'h0, 32'h0, 32'h0);
      end else if (p == 1) begin
        program_filter(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      end else begin
        sel = $urandom_range(0, 5);
        k = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom);
        program_filter(k, rand_thr(200 * 65536), rand_thr(2000), rand_thr(60));
      end
      tx_gap_pct = (p % 3 == 2) ? 0 : $urandom_range(10, 60);
      rx_stall_pct = (p % 4 == 3) ? 0 : $urandom_range(10, 60);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 85) s_walk = 16'(int'(s_walk) + int'($urandom_range(0, 200)) - 100);
        else s_walk = 16'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 90) t_walk = t_walk + $urandom_range(0, 20);
        else if (sel < 95) t_walk = $urandom;
        else t_walk = t_walk - $urandom_range(1, 50);
        offer_sample(s_walk, t_walk);
      end
    end
  endtask

  initial begin : main
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_sample();
    test_delta_check();
    test_time_check();
    test_max_age();
    test_ignored_index();
    test_backpressure();
    test_random_mix();
    quiesce();
    if (expected_reports.size() != 0) n_errors++;
    $display("covered %0d samples, %0d results checked, %0d reported as changes",
             n_accepted, n_checked, n_triggers);
    $display("%0d register writes across %0d filter settings, %0d mismatches",
             n_reg_writes, PHASES + 7, n_mismatch);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
